/* design/fc_pkg.sv */
package fc_pkg;

   localparam logic [31:0] SGL_INF     = 32'h7f80_0000;
   localparam logic [31:0] SCALED_INF  = 32'(31) << 23;
   localparam logic [31:0] ROUND_CLEAR = 32'h0000_0fff;
   localparam logic [31:0] ROUND_ADD   = 32'h0000_1000;
   localparam logic [15:0] HALF_QNAN   = 16'h7e00;
   localparam logic [15:0] HALF_INF    = 16'h7c00;
   localparam logic [31:0] EXP_BIAS_DN = 32'(112) << 23;

   typedef enum logic {
      ACT_TO_HALF   = 1'b0,
      ACT_TO_SINGLE = 1'b1
   } action_type;

   // stage one to stage two: classified source
   typedef struct packed {
      action_type  action;
      logic        sign;
      logic        is_inf;
      logic        is_nan;
      logic [30:0] mag;
      logic [15:0] half;
   } decode_type;

   // stage two to stage three: scaled magnitude or finished single
   typedef struct packed {
      action_type  action;
      logic        sign;
      logic        special;
      logic [15:0] special_half;
      logic [31:0] scaled;
      logic [31:0] single;
   } scale_type;

endpackage

/* design/fc_decode.sv */
module fc_decode (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  logic               in_action,
   input  logic [31:0]        in_value,
   output logic               out_valid,
   output fc_pkg::decode_type out_data
);

   logic               valid_ff;
   fc_pkg::decode_type data_ff;
   fc_pkg::decode_type data_in;

   always_comb begin
      data_in.action = fc_pkg::action_type'(in_action);
      data_in.sign   = in_value[31];
      data_in.is_inf = ({1'b0, in_value[30:0]} == fc_pkg::SGL_INF);
      data_in.is_nan = ({1'b0, in_value[30:0]} > fc_pkg::SGL_INF);
      data_in.mag    = in_value[30:0] & ~fc_pkg::ROUND_CLEAR[30:0];
      data_in.half   = in_value[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* design/fc_scale.sv */
module fc_scale (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  fc_pkg::decode_type in_data,
   output logic               out_valid,
   output fc_pkg::scale_type  out_data
);

   logic              valid_ff;
   fc_pkg::scale_type data_ff;
   fc_pkg::scale_type data_in;

   logic [7:0]  exp8;
   logic [24:0] sig;
   logic [7:0]  sh;
   logic [24:0] q;
   logic [24:0] rem;
   logic [24:0] halfw;
   logic [24:0] mask;
   logic [31:0] scaled;
   logic [4:0]  hexp;
   logic [9:0]  hmant;
   logic [3:0]  lead;
   logic [31:0] single;

   always_comb begin
      exp8  = in_data.mag[30:23];
      sig   = {2'b01, in_data.mag[22:0]};
      sh    = 8'd113 - exp8;
      q     = '0;
      rem   = '0;
      halfw = '0;
      mask  = '0;
      if (exp8 == 8'd0) begin
         scaled = '0;
      end else if (exp8 > 8'd112) begin
         scaled = {1'b0, in_data.mag} - fc_pkg::EXP_BIAS_DN;
      end else if (sh >= 8'd25) begin
         scaled = '0;
      end else begin
         q      = sig >> sh[4:0];
         mask   = (25'd1 << sh[4:0]) - 25'd1;
         rem    = sig & mask;
         halfw  = 25'd1 << (sh[4:0] - 5'd1);
         scaled = {7'd0, q};
         if (rem > halfw || (rem == halfw && q[0])) begin
            scaled = {7'd0, q} + 32'd1;
         end
      end

      hexp  = in_data.half[14:10];
      hmant = in_data.half[9:0];
      lead  = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (hmant[i]) begin
            lead = 4'(i);
         end
      end
      if (hexp == 5'd31) begin
         single = fc_pkg::SGL_INF | {9'd0, hmant, 13'd0};
      end else if (hexp == 5'd0) begin
         if (hmant == 10'd0) begin
            single = '0;
         end else begin
            single = {1'b0, 8'({4'd0, lead} + 8'd103),
                      23'({13'd0, hmant} << (5'd23 - {1'b0, lead}))};
         end
      end else begin
         single = {1'b0, 8'({3'd0, hexp} + 8'd112), hmant, 13'd0};
      end
      single[31] = in_data.half[15];

      data_in.action       = in_data.action;
      data_in.sign         = in_data.sign;
      data_in.special      = in_data.is_inf | in_data.is_nan;
      data_in.special_half = in_data.is_nan ? fc_pkg::HALF_QNAN : fc_pkg::HALF_INF;
      data_in.scaled       = scaled;
      data_in.single       = single;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* design/fc_pack.sv */
module fc_pack (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  fc_pkg::scale_type in_data,
   output logic              out_valid,
   output logic [31:0]       out_result
);

   logic        valid_ff;
   logic [31:0] result_ff;
   logic [31:0] result_in;
   logic [31:0] sum;
   logic [31:0] clamped;
   logic [15:0] half;

   always_comb begin
      sum     = in_data.scaled + fc_pkg::ROUND_ADD;
      clamped = (sum > fc_pkg::SCALED_INF) ? fc_pkg::SCALED_INF : sum;
      half    = in_data.special ? in_data.special_half : clamped[28:13];
      half[15] = in_data.sign;
      case (in_data.action)
         fc_pkg::ACT_TO_HALF:   result_in = {16'd0, half};
         fc_pkg::ACT_TO_SINGLE: result_in = in_data.single;
         default:               result_in = in_data.single;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

/* design/fp32_fp16_converter.sv */
// Path: each accepted request passes through the decode, scale and pack stages to its response.
// Throughput: one transaction per cycle while the output is not stalled; the three register stages advance together.
// Stall: a stalled valid output freezes the whole pipeline and stalls the request side.
// Reset: synchronous, active high; clears the stage valid bits only.
module fp32_fp16_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result
);

   logic               advance;
   logic               dec_valid;
   fc_pkg::decode_type dec_data;
   logic               scl_valid;
   fc_pkg::scale_type  scl_data;

   // advance unless the output holds an untaken transaction
   assign advance   = ~(rsp_valid & rsp_stall);
   assign req_stall = ~advance;

   fc_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_action (req_action),
      .in_value  (req_value),
      .out_valid (dec_valid),
      .out_data  (dec_data)
   );

   fc_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (dec_valid),
      .in_data   (dec_data),
      .out_valid (scl_valid),
      .out_data  (scl_data)
   );

   fc_pack u_pack (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (scl_valid),
      .in_data    (scl_data),
      .out_valid  (rsp_valid),
      .out_result (rsp_result)
   );

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_action;
   logic [31:0] req_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_result;

   typedef struct packed {
      fc_pkg::action_type action;
      logic [31:0]        value;
   } conv_item_type;

   conv_item_type pending_q[$];
   logic [31:0]   expected_q[$];
   int            errors = 0;
   int            send_wait = 0;
   int            recv_wait = 0;
   int            hold_off = 0;
   bit            hold_used = 0;
   int            sent = 0;

   fp32_fp16_converter dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [31:0] scale_mag(logic [31:0] mag);
      logic [31:0] ex, sig, q, rem, halfway;
      int          sh;
      ex = mag >> 23;
      if (ex == 0) return 32'd0;
      if (ex > 112) return mag - (32'd112 << 23);
      sig = (mag & 32'h7fffff) | 32'h800000;
      sh = 113 - ex;
      if (sh >= 25) return 32'd0;
      q = sig >> sh;
      rem = sig & ((32'd1 << sh) - 1);
      halfway = 32'd1 << (sh - 1);
      if (rem > halfway || (rem == halfway && q[0])) q = q + 1;
      return q;
   endfunction

   function automatic logic [31:0] convert_word(conv_item_type it);
      logic [31:0] mag, o;
      logic [15:0] h;
      logic [4:0]  hexp;
      logic [9:0]  mant;
      int          p;
      if (it.action == fc_pkg::ACT_TO_HALF) begin
         mag = {1'b0, it.value[30:0]};
         if (mag >= 32'h7f800000) begin
            o = (mag > 32'h7f800000) ? 32'h7e00 : 32'h7c00;
         end else begin
            mag = scale_mag(mag & ~32'hfff) + 32'h1000;
            if (mag > (32'd31 << 23)) mag = 32'd31 << 23;
            o = mag >> 13;
         end
         return {16'd0, it.value[31], o[14:0]};
      end
      h = it.value[15:0];
      hexp = h[14:10];
      mant = h[9:0];
      if (hexp == 5'd31) begin
         o = 32'h7f800000 | (32'(mant) << 13);
      end else if (hexp == 0) begin
         if (mant == 0) begin
            o = 0;
         end else begin
            p = 9;
            while (!mant[p]) p--;
            o = (32'(p + 103) << 23) | ((32'(mant) << (23 - p)) & 32'h7fffff);
         end
      end else begin
         o = (32'(hexp + 112) << 23) | (32'(mant) << 13);
      end
      return o | {h[15], 31'd0};
   endfunction

   function automatic logic [31:0] random_single();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 5))
         0: v[30:23] = 8'(112 + $urandom_range(0, 31));
         1: v[30:23] = 8'(100 + $urandom_range(0, 13));
         2: v[30:23] = 8'($urandom_range(142, 144));
         3: v[30:23] = $urandom_range(0, 1) ? 8'hff : 8'h00;
         default: ;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] random_half();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 3))
         0: v[14:10] = 5'd0;
         1: v[14:10] = 5'd31;
         default: ;
      endcase
      return v;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            sent++;
            expected_q.push_back(convert_word({fc_pkg::action_type'(req_action), req_value}));
         end
         if (!req_valid || !req_stall) begin
            if (send_wait > 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               conv_item_type it;
               it = pending_q.pop_front();
               req_valid <= 1'b1;
               req_action <= it.action;
               req_value <= it.value;
               send_wait = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("unexpected transaction: result %h", rsp_result);
               errors++;
            end else begin
               logic [31:0] exp_word;
               exp_word = expected_q.pop_front();
               if (rsp_result !== exp_word) begin
                  $error("result: expected %h actual %h", exp_word, rsp_result);
                  errors++;
               end
            end
         end
         if (hold_off > 0) begin
            hold_off--;
            rsp_stall <= 1'b1;
         end else if (!hold_used && sent > 400) begin
            hold_used = 1;
            hold_off = 60;
            rsp_stall <= 1'b1;
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0) recv_wait = $urandom_range(0, 18);
         end
      end
   end

   initial begin
      conv_item_type it;
      logic [31:0] dir_single[15];
      logic [31:0] dir_half[8];
      dir_single = '{32'h0000_0000, 32'h8000_0000, 32'h7f80_0000, 32'hff80_0000,
                     32'h7fc0_0001, 32'hff80_0001, 32'h0000_0001, 32'h807f_ffff,
                     32'h477f_e000, 32'h4780_0000, 32'h7f7f_ffff, 32'h3880_0000,
                     32'h3300_0000, 32'h3380_0000, 32'hffff_ffff};
      dir_half = '{32'h0000_0000, 32'hffff_8000, 32'h0000_0001, 32'h0000_03ff,
                   32'h1234_7c00, 32'h0000_fe01, 32'h0000_7bff, 32'hffff_ffff};
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = 1'b0;
      req_value = '0;
      rsp_stall = 1'b0;
      foreach (dir_single[i]) pending_q.push_back({fc_pkg::ACT_TO_HALF, dir_single[i]});
      foreach (dir_half[i]) pending_q.push_back({fc_pkg::ACT_TO_SINGLE, dir_half[i]});
      for (int i = 0; i < 1650; i++) begin
         it.action = fc_pkg::action_type'($urandom_range(0, 1));
         it.value = (it.action == fc_pkg::ACT_TO_HALF) ? random_single() : random_half();
         pending_q.push_back(it);
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      wait (pending_q.size() == 0);
      @(posedge clock);
      while (req_valid) @(posedge clock);
      while (expected_q.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
